>>> hdl/rau_pkg.sv
// ----------------------------------------------------------------------------
// rau_pkg: shared types and constants for the rational arithmetic unit
// Commands, payload structs and the front-to-back work descriptor.
// ----------------------------------------------------------------------------
`default_nettype none
package rau_pkg;

    localparam int OPERAND_WIDTH_DEF = 32;
    localparam int WIDE_W = 64;
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [3:0] {
        CMD_ADD   = 4'd0,
        CMD_SUB   = 4'd1,
        CMD_MUL   = 4'd2,
        CMD_DIV   = 4'd3,
        CMD_LESS  = 4'd4,
        CMD_GREAT = 4'd5,
        CMD_EQUAL = 4'd6,
        CMD_FLOOR = 4'd7,
        CMD_ROUND = 4'd8
    } cmd_t;

    typedef struct packed {
        logic [3:0]         command;
        logic signed [31:0] a_num;
        logic [30:0]        a_den;
        logic signed [31:0] b_num;
        logic [30:0]        b_den;
    } in_item_t;

    typedef struct packed {
        logic signed [63:0] res_num;
        logic [62:0]        res_den;
        logic               compare_flag;
        logic               div_by_zero;
    } out_item_t;

    // work kinds handed to the back end
    typedef enum logic [1:0] {
        JOB_DONE   = 2'd0,  // result already known
        JOB_REDUCE = 2'd1,  // reduce num/den by gcd
        JOB_FLOOR  = 2'd2,  // floor(num/den)
        JOB_ROUND  = 2'd3   // round half even(num/den)
    } job_t;

    typedef struct packed {
        job_t               job;
        logic signed [63:0] num;
        logic [63:0]        den;
        logic               compare_flag;
        logic               div_by_zero;
    } work_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_GCD,
        ST_DIV,
        ST_FIX,
        ST_OUT
    } back_state_t;

endpackage
`default_nettype wire

>>> hdl/rational_arithmetic_unit.sv
// ----------------------------------------------------------------------------
// rational_arithmetic_unit: exact rational ALU on reduced fractions
// Usage notes:
//   Input channel (valid/stall/data) carries a command and two fractions;
//   output channel (out_valid/out_stall/out_data) returns one reduced result
//   per item, in order. A transfer happens when valid is high, stall low.
//   Front end: captures operands, forms the four 32x32 cross products in a
//   registered step and classifies the item.
//   A two-entry queue sits between front and back.
//   Back end: Euclid gcd with a bit-serial 64-bit remainder unit, then two
//   exact divisions by the gcd. Floor and round use one division.
//   Compares and zero results go straight to the output.
//   The back end takes no new item until its current result has been
//   handed out, so the divider loop sets how fast reductions go through.
//   Reset clears all control state; no items are in flight afterwards.
//   While out_stall is high the result holds and the back end waits; the
//   queue and front end keep taking transfers until full.
// ----------------------------------------------------------------------------
`default_nettype none
module rational_arithmetic_unit
    import rau_pkg::*;
#(
    parameter int OPERAND_WIDTH = OPERAND_WIDTH_DEF
)(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     valid,
    output logic          stall,
    input  wire in_item_t data,
    output logic          out_valid,
    input  wire logic     out_stall,
    output out_item_t     out_data
);

    logic  fq_valid, fq_stall, qb_valid, qb_stall;
    work_t fq_work, qb_work;

    rau_front #(.OPERAND_WIDTH(OPERAND_WIDTH)) u_front (
        .clk, .rst_n, .valid, .stall, .data,
        .work_valid(fq_valid), .work_stall(fq_stall), .work(fq_work)
    );

    rau_queue u_queue (
        .clk, .rst_n,
        .wr_valid(fq_valid), .wr_stall(fq_stall), .wr_data(fq_work),
        .rd_valid(qb_valid), .rd_stall(qb_stall), .rd_data(qb_work)
    );

    rau_back u_back (
        .clk, .rst_n,
        .work_valid(qb_valid), .work_stall(qb_stall), .work(qb_work),
        .valid(out_valid), .stall(out_stall), .data(out_data)
    );

endmodule
`default_nettype wire

>>> hdl/rau_front.sv
// ----------------------------------------------------------------------------
// rau_front: operand decode and cross products
// Masks operands, forms cross products and classifies the item into a
// back-end job, over three registered steps.
// ----------------------------------------------------------------------------
`default_nettype none
module rau_front
    import rau_pkg::*;
#(
    parameter int OPERAND_WIDTH = OPERAND_WIDTH_DEF
)(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     valid,
    output logic          stall,
    input  wire in_item_t data,
    output logic          work_valid,
    input  wire logic     work_stall,
    output work_t         work
);

    localparam int DW = OPERAND_WIDTH - 1;

    // stage 0: captured operands, stage 1: products, stage 2: work
    logic                busy_reg, busy_next;
    logic [1:0]          step_reg, step_next;
    logic [3:0]          cmd_reg;
    logic signed [31:0]  an_reg, ad_reg, bn_reg, bd_reg;
    logic signed [63:0]  lhs_reg, rhs_reg, nn_reg, dd_reg;
    logic                out_v_reg, out_v_next;
    work_t               work_reg, work_next;

    function automatic logic signed [31:0] take_num(input logic [31:0] v);
        logic [OPERAND_WIDTH-1:0] x;
        x = v[OPERAND_WIDTH-1:0];
        return 32'(signed'(x));
    endfunction

    function automatic logic signed [31:0] take_den(input logic [30:0] v);
        logic [DW-1:0] x;
        x = v[DW-1:0];
        return (x == '0) ? 32'sd1 : signed'(32'(x));
    endfunction

    assign stall      = busy_reg;
    assign work_valid = out_v_reg;
    assign work       = work_reg;

    always_comb
    begin
        busy_next  = busy_reg;
        step_next  = step_reg;
        out_v_next = out_v_reg;
        work_next  = work_reg;
        if (out_v_reg && !work_stall)
        begin
            out_v_next = 1'b0;
            busy_next  = 1'b0;
        end
        if (valid && !busy_reg)
        begin
            busy_next = 1'b1;
            step_next = 2'd0;
        end
        else if (busy_reg && !out_v_reg)
        begin
            if (step_reg == 2'd0)
                step_next = 2'd1;
            else if (step_reg == 2'd1)
            begin
                step_next    = 2'd2;
                out_v_next   = 1'b1;
                work_next.num = '0;
                work_next.den = 64'd1;
                work_next.compare_flag = 1'b0;
                work_next.div_by_zero  = 1'b0;
                work_next.job = JOB_DONE;
                case (cmd_reg)
                    CMD_ADD:
                    begin
                        work_next.job = JOB_REDUCE;
                        work_next.num = lhs_reg + rhs_reg;
                        work_next.den = dd_reg;
                    end
                    CMD_SUB:
                    begin
                        work_next.job = JOB_REDUCE;
                        work_next.num = lhs_reg - rhs_reg;
                        work_next.den = dd_reg;
                    end
                    CMD_MUL:
                    begin
                        work_next.job = JOB_REDUCE;
                        work_next.num = nn_reg;
                        work_next.den = dd_reg;
                    end
                    CMD_DIV:
                    begin
                        if (bn_reg == 0)
                            work_next.div_by_zero = 1'b1;
                        else
                        begin
                            work_next.job = JOB_REDUCE;
                            work_next.num = bn_reg[31] ? -lhs_reg : lhs_reg;
                            work_next.den = bn_reg[31] ? 64'(-rhs_reg) : 64'(rhs_reg);
                        end
                    end
                    CMD_LESS:  work_next.compare_flag = lhs_reg < rhs_reg;
                    CMD_GREAT: work_next.compare_flag = lhs_reg > rhs_reg;
                    CMD_EQUAL: work_next.compare_flag = lhs_reg == rhs_reg;
                    CMD_FLOOR, CMD_ROUND:
                    begin
                        work_next.job = (cmd_reg == CMD_ROUND) ? JOB_ROUND : JOB_FLOOR;
                        work_next.num = 64'(an_reg);
                        work_next.den = 64'(ad_reg);
                    end
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            out_v_reg <= 1'b0;
            step_reg  <= 2'd0;
        end
        else
        begin
            busy_reg  <= busy_next;
            out_v_reg <= out_v_next;
            step_reg  <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg <= work_next;
        if (valid && !busy_reg)
        begin
            cmd_reg <= data.command;
            an_reg  <= take_num(data.a_num);
            ad_reg  <= take_den(data.a_den);
            bn_reg  <= take_num(data.b_num);
            bd_reg  <= take_den(data.b_den);
        end
        else if (busy_reg && step_reg == 2'd0)
        begin
            // one 32x32 product per term, registered
            lhs_reg <= 64'(an_reg) * 64'(bd_reg);
            rhs_reg <= 64'(bn_reg) * 64'(ad_reg);
            nn_reg  <= 64'(an_reg) * 64'(bn_reg);
            dd_reg  <= 64'(ad_reg) * 64'(bd_reg);
        end
    end

endmodule
`default_nettype wire

>>> hdl/rau_queue.sv
// ----------------------------------------------------------------------------
// rau_queue: small work queue between front and back
// Two-entry FIFO so the front and back stall independently.
// ----------------------------------------------------------------------------
`default_nettype none
module rau_queue
    import rau_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  wr_valid,
    output logic       wr_stall,
    input  wire work_t wr_data,
    output logic       rd_valid,
    input  wire logic  rd_stall,
    output work_t      rd_data
);

    localparam int AW = $clog2(QUEUE_DEPTH);

    work_t        mem [QUEUE_DEPTH];
    logic [AW-1:0] wp_reg, rp_reg;
    logic [AW:0]   cnt_reg;
    logic          wr_en, rd_en;

    assign wr_stall = (cnt_reg == (AW+1)'(QUEUE_DEPTH));
    assign rd_valid = (cnt_reg != '0);
    assign rd_data  = mem[rp_reg];
    assign wr_en    = wr_valid && !wr_stall;
    assign rd_en    = rd_valid && !rd_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (wr_en)
                wp_reg <= wp_reg + 1'b1;
            if (rd_en)
                rp_reg <= rp_reg + 1'b1;
            cnt_reg <= cnt_reg + (AW+1)'(wr_en) - (AW+1)'(rd_en);
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wp_reg] <= wr_data;
    end

endmodule
`default_nettype wire

>>> hdl/rau_back.sv
// ----------------------------------------------------------------------------
// rau_back: gcd reduction and floor/round division
// Euclid by restoring division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module rau_back
    import rau_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  work_valid,
    output logic       work_stall,
    input  wire work_t work,
    output logic       valid,
    input  wire logic  stall,
    output out_item_t  data
);

    back_state_t       state_reg, state_next;
    job_t              job_reg;
    logic              neg_reg, cf_reg, dz_reg;
    logic [63:0]       mag_reg, den_reg;       // original magnitude / den
    logic [63:0]       p_reg, q_reg;           // gcd pair
    logic [63:0]       dvd_reg, dvs_reg;       // divider operands
    logic [63:0]       quo_reg, rem_reg;
    logic [6:0]        bit_reg;
    logic [1:0]        phase_reg;              // 0 gcd step, 1 mag/g, 2 den/g, 3 floor/round
    out_item_t         out_reg;
    logic [64:0]       trial;
    logic [63:0]       rem_sh;

    assign work_stall = (state_reg != ST_IDLE);
    assign valid      = (state_reg == ST_OUT);
    assign data       = out_reg;
    assign rem_sh     = {rem_reg[62:0], dvd_reg[63]};
    assign trial      = {1'b0, rem_sh} - {1'b0, dvs_reg};

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (work_valid)
                    state_next = (work.job == JOB_DONE || work.num == 0) ? ST_OUT :
                                 (work.job == JOB_REDUCE) ? ST_GCD : ST_DIV;
            ST_GCD:
                if (q_reg == 0)
                    state_next = ST_DIV;
            ST_DIV:
                if (bit_reg == 7'd0)
                    state_next = ST_FIX;
            ST_FIX:
                state_next = (job_reg == JOB_REDUCE && phase_reg != 2'd2) ? ST_DIV : ST_OUT;
            ST_OUT:
                if (!stall)
                    state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
                if (work_valid)
                begin
                    job_reg   <= work.job;
                    neg_reg   <= work.num[63];
                    mag_reg   <= work.num[63] ? 64'(-work.num) : 64'(work.num);
                    den_reg   <= work.den;
                    p_reg     <= work.num[63] ? 64'(-work.num) : 64'(work.num);
                    q_reg     <= work.den;
                    // gcd steps start with p mod q
                    dvd_reg   <= work.num[63] ? 64'(-work.num) : 64'(work.num);
                    dvs_reg   <= work.den;
                    rem_reg   <= '0;
                    quo_reg   <= '0;
                    bit_reg   <= 7'd63;
                    phase_reg <= (work.job == JOB_REDUCE) ? 2'd0 : 2'd3;
                    out_reg.res_num      <= '0;
                    out_reg.res_den      <= 63'd1;
                    out_reg.compare_flag <= work.compare_flag;
                    out_reg.div_by_zero  <= work.div_by_zero;
                    cf_reg <= work.compare_flag;
                    dz_reg <= work.div_by_zero;
                end
            ST_GCD:
            begin
                // one remainder bit per cycle for p mod q
                if (q_reg != 0)
                begin
                    if (bit_reg == 7'd0)
                    begin
                        p_reg   <= q_reg;
                        q_reg   <= !trial[64] ? trial[63:0] : rem_sh;
                        dvd_reg <= q_reg;
                        dvs_reg <= !trial[64] ? trial[63:0] : rem_sh;
                        rem_reg <= '0;
                        bit_reg <= 7'd63;
                    end
                    else
                    begin
                        rem_reg <= !trial[64] ? trial[63:0] : rem_sh;
                        dvd_reg <= {dvd_reg[62:0], 1'b0};
                        bit_reg <= bit_reg - 7'd1;
                    end
                end
                else
                begin
                    // gcd found in p: divide magnitude next
                    dvd_reg   <= mag_reg;
                    dvs_reg   <= p_reg;
                    rem_reg   <= '0;
                    quo_reg   <= '0;
                    bit_reg   <= 7'd63;
                    phase_reg <= 2'd1;
                end
            end
            ST_DIV:
            begin
                if (!trial[64])
                    rem_reg <= trial[63:0];
                else
                    rem_reg <= rem_sh;
                quo_reg <= {quo_reg[62:0], !trial[64]};
                dvd_reg <= {dvd_reg[62:0], 1'b0};
                bit_reg <= bit_reg - 7'd1;
            end
            ST_FIX:
            begin
                if (phase_reg == 2'd1)
                begin
                    out_reg.res_num <= neg_reg ? 64'(-quo_reg) : quo_reg;
                    dvd_reg   <= den_reg;
                    rem_reg   <= '0;
                    quo_reg   <= '0;
                    bit_reg   <= 7'd63;
                    phase_reg <= 2'd2;
                end
                else if (phase_reg == 2'd2)
                    out_reg.res_den <= quo_reg[62:0];
                else
                begin
                    // floor / round on magnitude quotient and remainder
                    logic signed [63:0] qs;
                    logic [63:0]        rs;
                    logic               up;
                    qs = neg_reg ? 64'(-quo_reg) : quo_reg;
                    rs = rem_reg;
                    if (neg_reg && rem_reg != 0)
                    begin
                        qs = qs - 64'sd1;
                        rs = den_reg - rem_reg;
                    end
                    up = 1'b0;
                    if (job_reg == JOB_ROUND)
                        up = ({rs, 1'b0} > {1'b0, den_reg}) ||
                             ({rs, 1'b0} == {1'b0, den_reg} && qs[0]);
                    out_reg.res_num <= qs + 64'(up);
                    out_reg.res_den <= 63'd1;
                end
                out_reg.compare_flag <= cf_reg;
                out_reg.div_by_zero  <= dz_reg;
            end
            default: ;
        endcase
    end

endmodule
`default_nettype wire

>>> hdl/rau_checker.sv
// ----------------------------------------------------------------------------
// rau_checker: port-level assertions
// Checks result consistency seen at the top-level ports.
// ----------------------------------------------------------------------------
`default_nettype none
module rau_checker
    import rau_pkg::*;
(
    input wire logic      clk,
    input wire logic      rst_n,
    input wire logic      out_valid,
    input wire logic      out_stall,
    input wire out_item_t out_data
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    a_den_pos: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.res_den != '0)
        else $error("zero denominator");

    a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.div_by_zero |-> out_data.res_num == '0)
        else $error("divide by zero with nonzero result");

    a_flags: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(out_data.compare_flag && out_data.div_by_zero))
        else $error("both flags set");

endmodule

bind rational_arithmetic_unit rau_checker u_rau_checker (
    .clk, .rst_n, .out_valid, .out_stall, .out_data
);
`default_nettype wire

>>> tb/rational_arithmetic_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rational_arithmetic_unit_tb: self-checking bench for the rational ALU
// A directed table of operand extremes and rounding/compare corner cases,
// then random fractions under four idling phases. Every result transfer is
// compared field by field against its table row or a rational predictor.
// ----------------------------------------------------------------------------
`default_nettype none
module rational_arithmetic_unit_tb;
    import rau_pkg::*;

    localparam logic [3:0] CMD_UNUSED = 4'hF;   // no operation defined
    localparam int STALL_LIMIT = 50000;         // cycles without any transfer
    localparam int HOLD_CYCLES = 3000;          // long receiver hold-off
    localparam int ITEMS_PER_PHASE = 210;
    localparam int DRAIN_CYCLES = 8000;         // worst reduction latency, with margin

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      valid = 1'b0;
    logic      stall;
    in_item_t  data = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    out_item_t out_data;

    rational_arithmetic_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .valid    (valid),
        .stall    (stall),
        .data     (data),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_data (out_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // expected results, oldest first
    out_item_t pending_results[$];
    int errors = 0;
    int results_seen = 0;
    int sent = 0;
    int idle_pct = 0;           // sender gap probability, percent
    int stall_pct = 0;          // receiver stall probability, percent
    int hold_requests = 0;      // bumped by the stimulus to ask for a hold-off
    int hold_served = 0;
    int hold_left = 0;
    int quiet_cycles = 0;
    int cmd_count[16];

    // ------------------------------------------------------------------
    // Rational predictor
    // ------------------------------------------------------------------
    function automatic logic [63:0] gcd64(logic [63:0] p, logic [63:0] q);
        logic [63:0] t;
        while (q != 0)
        begin
            t = p % q;
            p = q;
            q = t;
        end
        return p;
    endfunction

    // num/den with den > 0 -> fully reduced fraction, zero becomes 0/1
    function automatic void reduce_frac(longint num, longint den, ref out_item_t r);
        logic        neg;
        logic [63:0] mag;
        logic [63:0] d;
        logic [63:0] g;
        neg = num < 0;
        mag = neg ? 64'd0 - 64'(num) : 64'(num);
        d = 64'(den);
        if (mag == 0)
        begin
            d = 64'd1;
        end
        else
        begin
            g = gcd64(mag, d);
            mag = mag / g;
            d = d / g;
        end
        r.res_num = neg ? 64'd0 - mag : mag;
        r.res_den = d[62:0];
    endfunction

    function automatic out_item_t predict_rational(in_item_t it);
        out_item_t r;
        longint an, ad, bn, bd, lhs, rhs, q, rem;
        an = longint'(it.a_num);
        bn = longint'(it.b_num);
        ad = (it.a_den == 0) ? 1 : longint'({33'd0, it.a_den});
        bd = (it.b_den == 0) ? 1 : longint'({33'd0, it.b_den});
        lhs = an * bd;
        rhs = bn * ad;
        r = '0;
        r.res_den = 63'd1;
        case (it.command)
            CMD_ADD:   reduce_frac(lhs + rhs, ad * bd, r);
            CMD_SUB:   reduce_frac(lhs - rhs, ad * bd, r);
            CMD_MUL:   reduce_frac(an * bn, ad * bd, r);
            CMD_DIV:
            begin
                if (bn == 0)
                    r.div_by_zero = 1'b1;
                else if (bn < 0)
                    reduce_frac(-lhs, -rhs, r);
                else
                    reduce_frac(lhs, rhs, r);
            end
            CMD_LESS:  r.compare_flag = lhs < rhs;
            CMD_GREAT: r.compare_flag = lhs > rhs;
            CMD_EQUAL: r.compare_flag = lhs == rhs;
            CMD_FLOOR, CMD_ROUND:
            begin
                q = an / ad;
                rem = an - q * ad;
                if (rem < 0)
                begin
                    q = q - 1;
                    rem = rem + ad;
                end
                // halves go to the even neighbor
                if (it.command == CMD_ROUND &&
                    (2 * rem > ad || (2 * rem == ad && q[0])))
                    q = q + 1;
                r.res_num = q;
            end
            default: ;
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Sender: one transfer per call, random gaps ahead of it
    // ------------------------------------------------------------------
    task automatic send_item(in_item_t it, bit use_typed, out_item_t typed);
        while ($urandom_range(99) < idle_pct)
        begin
            valid <= 1'b0;
            @(posedge clk);
        end
        valid <= 1'b1;
        data <= it;
        do
            @(posedge clk);
        while (stall);
        pending_results.push_back(use_typed ? typed : predict_rational(it));
        cmd_count[it.command]++;
        sent++;
    endtask

    task automatic wait_drained();
        valid <= 1'b0;
        wait (pending_results.size() == 0);
        @(posedge clk);
    endtask

    // random operand parts, weighted toward small values to keep gcd loops short
    function automatic logic [31:0] rand_num();
        int pick;
        pick = $urandom_range(99);
        if (pick < 55)
            return 32'($signed($urandom_range(200)) - 100);
        else if (pick < 80)
            return 32'($signed($urandom_range(131070)) - 65535);
        else if (pick < 95)
            return $urandom();
        else
            return pick[0] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    endfunction

    function automatic logic [30:0] rand_den();
        int pick;
        pick = $urandom_range(99);
        if (pick < 3)
            return 31'd0;           // read as 1
        else if (pick < 60)
            return 31'($urandom_range(100, 1));
        else if (pick < 82)
            return 31'($urandom_range(65535, 1));
        else if (pick < 96)
            return 31'($urandom());
        else
            return 31'h7FFF_FFFF;
    endfunction

    function automatic in_item_t rand_item();
        in_item_t it;
        it.command = ($urandom_range(99) < 4) ? 4'($urandom_range(15, 9))
                                              : 4'($urandom_range(8));
        it.a_num = rand_num();
        it.a_den = rand_den();
        it.b_num = ($urandom_range(9) == 0) ? 32'd0 : rand_num();
        it.b_den = rand_den();
        return it;
    endfunction

    // ------------------------------------------------------------------
    // Directed table
    // ------------------------------------------------------------------
    typedef struct {
        in_item_t  item;
        bit        typed;       // expectation written in the row
        out_item_t result;
    } directed_row_t;

    localparam logic signed [31:0] NMAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] NMIN = 32'sh8000_0000;
    localparam logic [30:0] DMAX = 31'h7FFF_FFFF;

    directed_row_t directed[] = '{
        '{'{CMD_ADD, 32'sd0, 31'd1, 32'sd0, 31'd1}, 1, '{64'sd0, 63'd1, 1'b0, 1'b0}},
        '{'{CMD_ADD, NMAX, 31'd1, NMAX, 31'd1}, 1,
          '{64'sd4294967294, 63'd1, 1'b0, 1'b0}},
        '{'{CMD_SUB, NMIN, 31'd1, NMAX, 31'd1}, 1,
          '{-64'sd4294967295, 63'd1, 1'b0, 1'b0}},
        '{'{CMD_MUL, NMIN, 31'd1, NMIN, 31'd1}, 1,
          '{64'sh4000_0000_0000_0000, 63'd1, 1'b0, 1'b0}},
        '{'{CMD_DIV, 32'sd5, 31'd3, 32'sd0, 31'd7}, 1, '{64'sd0, 63'd1, 1'b0, 1'b1}},
        '{'{CMD_LESS, 32'sd1, 31'd2, 32'sd1, 31'd3}, 1, '{64'sd0, 63'd1, 1'b0, 1'b0}},
        '{'{CMD_GREAT, NMAX, 31'd1, NMIN, 31'd1}, 1, '{64'sd0, 63'd1, 1'b1, 1'b0}},
        '{'{CMD_EQUAL, 32'sd1, 31'd2, 32'sd2, 31'd4}, 1, '{64'sd0, 63'd1, 1'b1, 1'b0}},
        '{'{CMD_FLOOR, -32'sd7, 31'd2, 32'sd0, 31'd1}, 1, '{-64'sd4, 63'd1, 1'b0, 1'b0}},
        '{'{CMD_ROUND, 32'sd5, 31'd2, 32'sd0, 31'd1}, 1, '{64'sd2, 63'd1, 1'b0, 1'b0}},
        '{'{CMD_ROUND, -32'sd5, 31'd2, 32'sd0, 31'd1}, 1, '{-64'sd2, 63'd1, 1'b0, 1'b0}},
        '{'{CMD_ROUND, 32'sd7, 31'd2, 32'sd0, 31'd1}, 1, '{64'sd4, 63'd1, 1'b0, 1'b0}},
        '{'{CMD_ROUND, -32'sd3, 31'd2, 32'sd0, 31'd1}, 1, '{-64'sd2, 63'd1, 1'b0, 1'b0}},
        // zero denominator reads as 1
        '{'{CMD_ADD, 32'sd3, 31'd0, 32'sd0, 31'd1}, 1, '{64'sd3, 63'd1, 1'b0, 1'b0}},
        '{'{CMD_UNUSED, NMAX, DMAX, NMIN, DMAX}, 1, '{64'sd0, 63'd1, 1'b0, 1'b0}},
        // predictor-checked rows
        '{'{CMD_ADD, NMAX, DMAX, NMIN, 31'd1}, 0, '0},
        '{'{CMD_SUB, NMIN, DMAX, NMAX, 31'h7FFF_FFFE}, 0, '0},
        '{'{CMD_MUL, NMAX, 31'd3, NMIN, DMAX}, 0, '0},
        '{'{CMD_DIV, NMIN, 31'd1, -32'sd1, DMAX}, 0, '0},
        '{'{CMD_DIV, 32'sd6, 31'd4, 32'sd9, 31'd12}, 0, '0},
        '{'{CMD_EQUAL, NMAX, DMAX, 32'sd1, 31'd1}, 0, '0},
        '{'{CMD_LESS, NMIN, 31'd1, NMIN, DMAX}, 0, '0},
        '{'{CMD_FLOOR, NMIN, DMAX, 32'sd0, 31'd1}, 0, '0},
        '{'{CMD_ROUND, NMAX, 31'd2, 32'sd0, 31'd1}, 0, '0}
    };

    // ------------------------------------------------------------------
    // Receiver stall: random, or a long counted hold-off on request
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (hold_served < hold_requests)
        begin
            hold_served <= hold_served + 1;
            hold_left <= HOLD_CYCLES;
            out_stall <= 1'b1;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // Result check against the oldest expectation
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        out_item_t want;
        if (out_valid && !out_stall)
        begin
            results_seen++;
            if (pending_results.size() == 0)
            begin
                $error("result transfer with no expectation pending");
                errors++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (out_data.res_num !== want.res_num)
                begin
                    $error("res_num: expected %0d, got %0d", want.res_num, out_data.res_num);
                    errors++;
                end
                if (out_data.res_den !== want.res_den)
                begin
                    $error("res_den: expected %0d, got %0d", want.res_den, out_data.res_den);
                    errors++;
                end
                if (out_data.compare_flag !== want.compare_flag)
                begin
                    $error("compare_flag: expected %0b, got %0b",
                           want.compare_flag, out_data.compare_flag);
                    errors++;
                end
                if (out_data.div_by_zero !== want.div_by_zero)
                begin
                    $error("div_by_zero: expected %0b, got %0b",
                           want.div_by_zero, out_data.div_by_zero);
                    errors++;
                end
            end
        end
    end

    // watchdog: too long without any transfer on either side
    always @(posedge clk)
    begin
        if ((valid && !stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
            $display("simulation failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial
    begin
        int phase_idle[4] = '{0, 63, 0, 29};
        int phase_stall[4] = '{0, 0, 63, 29};
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
            send_item(directed[i].item, directed[i].typed, directed[i].result);
        wait_drained();

        for (int p = 0; p < 4; p++)
        begin
            idle_pct = phase_idle[p];
            stall_pct = phase_stall[p];
            // first phase: hold the output off while items keep coming,
            // so the queue fills and input stall shows up
            if (p == 0)
                hold_requests++;
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
                send_item(rand_item(), 0, '0);
            // sender pauses until the block is empty
            wait_drained();
        end

        stall_pct = 0;
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d transfers, %0d results; adds %0d, divides %0d, rounds %0d,",
                 sent, results_seen, cmd_count[CMD_ADD], cmd_count[CMD_DIV],
                 cmd_count[CMD_ROUND]);
        $display("under no idling, sender gaps, receiver stalls, both, and a long hold-off");
        if (errors == 0 && pending_results.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
`default_nettype wire

>>> rational_arithmetic_unit.f
hdl/rau_pkg.sv
hdl/rau_front.sv
hdl/rau_queue.sv
hdl/rau_back.sv
hdl/rational_arithmetic_unit.sv
hdl/rau_checker.sv
tb/rational_arithmetic_unit_tb.sv
